FILE: rtl/aes_cbc_pkg.sv
package aes_cbc_pkg;

    localparam int KEY_REGS = 4;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_IV_HI = 3'd4;
    localparam logic [2:0] REG_IV_LO = 3'd5;
    localparam logic [2:0] REG_MODE  = 3'd6;

    localparam logic [7:0] RCON_INIT = 8'h01;

    typedef logic [7:0] byte_t;

    function automatic byte_t xtime(input byte_t x);
        xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic byte_t fwd_sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h63; 8'h01: r=8'h7C; 8'h02: r=8'h77; 8'h03: r=8'h7B;
            8'h04: r=8'hF2; 8'h05: r=8'h6B; 8'h06: r=8'h6F; 8'h07: r=8'hC5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0A: r=8'h67; 8'h0B: r=8'h2B;
            8'h0C: r=8'hFE; 8'h0D: r=8'hD7; 8'h0E: r=8'hAB; 8'h0F: r=8'h76;
            8'h10: r=8'hCA; 8'h11: r=8'h82; 8'h12: r=8'hC9; 8'h13: r=8'h7D;
            8'h14: r=8'hFA; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hF0;
            8'h18: r=8'hAD; 8'h19: r=8'hD4; 8'h1A: r=8'hA2; 8'h1B: r=8'hAF;
            8'h1C: r=8'h9C; 8'h1D: r=8'hA4; 8'h1E: r=8'h72; 8'h1F: r=8'hC0;
            8'h20: r=8'hB7; 8'h21: r=8'hFD; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3F; 8'h26: r=8'hF7; 8'h27: r=8'hCC;
            8'h28: r=8'h34; 8'h29: r=8'hA5; 8'h2A: r=8'hE5; 8'h2B: r=8'hF1;
            8'h2C: r=8'h71; 8'h2D: r=8'hD8; 8'h2E: r=8'h31; 8'h2F: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hC7; 8'h32: r=8'h23; 8'h33: r=8'hC3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9A;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3A: r=8'h80; 8'h3B: r=8'hE2;
            8'h3C: r=8'hEB; 8'h3D: r=8'h27; 8'h3E: r=8'hB2; 8'h3F: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2C; 8'h43: r=8'h1A;
            8'h44: r=8'h1B; 8'h45: r=8'h6E; 8'h46: r=8'h5A; 8'h47: r=8'hA0;
            8'h48: r=8'h52; 8'h49: r=8'h3B; 8'h4A: r=8'hD6; 8'h4B: r=8'hB3;
            8'h4C: r=8'h29; 8'h4D: r=8'hE3; 8'h4E: r=8'h2F; 8'h4F: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hD1; 8'h52: r=8'h00; 8'h53: r=8'hED;
            8'h54: r=8'h20; 8'h55: r=8'hFC; 8'h56: r=8'hB1; 8'h57: r=8'h5B;
            8'h58: r=8'h6A; 8'h59: r=8'hCB; 8'h5A: r=8'hBE; 8'h5B: r=8'h39;
            8'h5C: r=8'h4A; 8'h5D: r=8'h4C; 8'h5E: r=8'h58; 8'h5F: r=8'hCF;
            8'h60: r=8'hD0; 8'h61: r=8'hEF; 8'h62: r=8'hAA; 8'h63: r=8'hFB;
            8'h64: r=8'h43; 8'h65: r=8'h4D; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hF9; 8'h6A: r=8'h02; 8'h6B: r=8'h7F;
            8'h6C: r=8'h50; 8'h6D: r=8'h3C; 8'h6E: r=8'h9F; 8'h6F: r=8'hA8;
            8'h70: r=8'h51; 8'h71: r=8'hA3; 8'h72: r=8'h40; 8'h73: r=8'h8F;
            8'h74: r=8'h92; 8'h75: r=8'h9D; 8'h76: r=8'h38; 8'h77: r=8'hF5;
            8'h78: r=8'hBC; 8'h79: r=8'hB6; 8'h7A: r=8'hDA; 8'h7B: r=8'h21;
            8'h7C: r=8'h10; 8'h7D: r=8'hFF; 8'h7E: r=8'hF3; 8'h7F: r=8'hD2;
            8'h80: r=8'hCD; 8'h81: r=8'h0C; 8'h82: r=8'h13; 8'h83: r=8'hEC;
            8'h84: r=8'h5F; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hC4; 8'h89: r=8'hA7; 8'h8A: r=8'h7E; 8'h8B: r=8'h3D;
            8'h8C: r=8'h64; 8'h8D: r=8'h5D; 8'h8E: r=8'h19; 8'h8F: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4F; 8'h93: r=8'hDC;
            8'h94: r=8'h22; 8'h95: r=8'h2A; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hEE; 8'h9A: r=8'hB8; 8'h9B: r=8'h14;
            8'h9C: r=8'hDE; 8'h9D: r=8'h5E; 8'h9E: r=8'h0B; 8'h9F: r=8'hDB;
            8'hA0: r=8'hE0; 8'hA1: r=8'h32; 8'hA2: r=8'h3A; 8'hA3: r=8'h0A;
            8'hA4: r=8'h49; 8'hA5: r=8'h06; 8'hA6: r=8'h24; 8'hA7: r=8'h5C;
            8'hA8: r=8'hC2; 8'hA9: r=8'hD3; 8'hAA: r=8'hAC; 8'hAB: r=8'h62;
            8'hAC: r=8'h91; 8'hAD: r=8'h95; 8'hAE: r=8'hE4; 8'hAF: r=8'h79;
            8'hB0: r=8'hE7; 8'hB1: r=8'hC8; 8'hB2: r=8'h37; 8'hB3: r=8'h6D;
            8'hB4: r=8'h8D; 8'hB5: r=8'hD5; 8'hB6: r=8'h4E; 8'hB7: r=8'hA9;
            8'hB8: r=8'h6C; 8'hB9: r=8'h56; 8'hBA: r=8'hF4; 8'hBB: r=8'hEA;
            8'hBC: r=8'h65; 8'hBD: r=8'h7A; 8'hBE: r=8'hAE; 8'hBF: r=8'h08;
            8'hC0: r=8'hBA; 8'hC1: r=8'h78; 8'hC2: r=8'h25; 8'hC3: r=8'h2E;
            8'hC4: r=8'h1C; 8'hC5: r=8'hA6; 8'hC6: r=8'hB4; 8'hC7: r=8'hC6;
            8'hC8: r=8'hE8; 8'hC9: r=8'hDD; 8'hCA: r=8'h74; 8'hCB: r=8'h1F;
            8'hCC: r=8'h4B; 8'hCD: r=8'hBD; 8'hCE: r=8'h8B; 8'hCF: r=8'h8A;
            8'hD0: r=8'h70; 8'hD1: r=8'h3E; 8'hD2: r=8'hB5; 8'hD3: r=8'h66;
            8'hD4: r=8'h48; 8'hD5: r=8'h03; 8'hD6: r=8'hF6; 8'hD7: r=8'h0E;
            8'hD8: r=8'h61; 8'hD9: r=8'h35; 8'hDA: r=8'h57; 8'hDB: r=8'hB9;
            8'hDC: r=8'h86; 8'hDD: r=8'hC1; 8'hDE: r=8'h1D; 8'hDF: r=8'h9E;
            8'hE0: r=8'hE1; 8'hE1: r=8'hF8; 8'hE2: r=8'h98; 8'hE3: r=8'h11;
            8'hE4: r=8'h69; 8'hE5: r=8'hD9; 8'hE6: r=8'h8E; 8'hE7: r=8'h94;
            8'hE8: r=8'h9B; 8'hE9: r=8'h1E; 8'hEA: r=8'h87; 8'hEB: r=8'hE9;
            8'hEC: r=8'hCE; 8'hED: r=8'h55; 8'hEE: r=8'h28; 8'hEF: r=8'hDF;
            8'hF0: r=8'h8C; 8'hF1: r=8'hA1; 8'hF2: r=8'h89; 8'hF3: r=8'h0D;
            8'hF4: r=8'hBF; 8'hF5: r=8'hE6; 8'hF6: r=8'h42; 8'hF7: r=8'h68;
            8'hF8: r=8'h41; 8'hF9: r=8'h99; 8'hFA: r=8'h2D; 8'hFB: r=8'h0F;
            8'hFC: r=8'hB0; 8'hFD: r=8'h54; 8'hFE: r=8'hBB; default: r=8'h16;
        endcase
        fwd_sbox = r;
    endfunction

    function automatic byte_t rev_sbox(input byte_t x);
        byte_t r;
        case (x)
            8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6A; 8'h03: r=8'hD5;
            8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'hA5; 8'h07: r=8'h38;
            8'h08: r=8'hBF; 8'h09: r=8'h40; 8'h0A: r=8'hA3; 8'h0B: r=8'h9E;
            8'h0C: r=8'h81; 8'h0D: r=8'hF3; 8'h0E: r=8'hD7; 8'h0F: r=8'hFB;
            8'h10: r=8'h7C; 8'h11: r=8'hE3; 8'h12: r=8'h39; 8'h13: r=8'h82;
            8'h14: r=8'h9B; 8'h15: r=8'h2F; 8'h16: r=8'hFF; 8'h17: r=8'h87;
            8'h18: r=8'h34; 8'h19: r=8'h8E; 8'h1A: r=8'h43; 8'h1B: r=8'h44;
            8'h1C: r=8'hC4; 8'h1D: r=8'hDE; 8'h1E: r=8'hE9; 8'h1F: r=8'hCB;
            8'h20: r=8'h54; 8'h21: r=8'h7B; 8'h22: r=8'h94; 8'h23: r=8'h32;
            8'h24: r=8'hA6; 8'h25: r=8'hC2; 8'h26: r=8'h23; 8'h27: r=8'h3D;
            8'h28: r=8'hEE; 8'h29: r=8'h4C; 8'h2A: r=8'h95; 8'h2B: r=8'h0B;
            8'h2C: r=8'h42; 8'h2D: r=8'hFA; 8'h2E: r=8'hC3; 8'h2F: r=8'h4E;
            8'h30: r=8'h08; 8'h31: r=8'h2E; 8'h32: r=8'hA1; 8'h33: r=8'h66;
            8'h34: r=8'h28; 8'h35: r=8'hD9; 8'h36: r=8'h24; 8'h37: r=8'hB2;
            8'h38: r=8'h76; 8'h39: r=8'h5B; 8'h3A: r=8'hA2; 8'h3B: r=8'h49;
            8'h3C: r=8'h6D; 8'h3D: r=8'h8B; 8'h3E: r=8'hD1; 8'h3F: r=8'h25;
            8'h40: r=8'h72; 8'h41: r=8'hF8; 8'h42: r=8'hF6; 8'h43: r=8'h64;
            8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
            8'h48: r=8'hD4; 8'h49: r=8'hA4; 8'h4A: r=8'h5C; 8'h4B: r=8'hCC;
            8'h4C: r=8'h5D; 8'h4D: r=8'h65; 8'h4E: r=8'hB6; 8'h4F: r=8'h92;
            8'h50: r=8'h6C; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
            8'h54: r=8'hFD; 8'h55: r=8'hED; 8'h56: r=8'hB9; 8'h57: r=8'hDA;
            8'h58: r=8'h5E; 8'h59: r=8'h15; 8'h5A: r=8'h46; 8'h5B: r=8'h57;
            8'h5C: r=8'hA7; 8'h5D: r=8'h8D; 8'h5E: r=8'h9D; 8'h5F: r=8'h84;
            8'h60: r=8'h90; 8'h61: r=8'hD8; 8'h62: r=8'hAB; 8'h63: r=8'h00;
            8'h64: r=8'h8C; 8'h65: r=8'hBC; 8'h66: r=8'hD3; 8'h67: r=8'h0A;
            8'h68: r=8'hF7; 8'h69: r=8'hE4; 8'h6A: r=8'h58; 8'h6B: r=8'h05;
            8'h6C: r=8'hB8; 8'h6D: r=8'hB3; 8'h6E: r=8'h45; 8'h6F: r=8'h06;
            8'h70: r=8'hD0; 8'h71: r=8'h2C; 8'h72: r=8'h1E; 8'h73: r=8'h8F;
            8'h74: r=8'hCA; 8'h75: r=8'h3F; 8'h76: r=8'h0F; 8'h77: r=8'h02;
            8'h78: r=8'hC1; 8'h79: r=8'hAF; 8'h7A: r=8'hBD; 8'h7B: r=8'h03;
            8'h7C: r=8'h01; 8'h7D: r=8'h13; 8'h7E: r=8'h8A; 8'h7F: r=8'h6B;
            8'h80: r=8'h3A; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
            8'h84: r=8'h4F; 8'h85: r=8'h67; 8'h86: r=8'hDC; 8'h87: r=8'hEA;
            8'h88: r=8'h97; 8'h89: r=8'hF2; 8'h8A: r=8'hCF; 8'h8B: r=8'hCE;
            8'h8C: r=8'hF0; 8'h8D: r=8'hB4; 8'h8E: r=8'hE6; 8'h8F: r=8'h73;
            8'h90: r=8'h96; 8'h91: r=8'hAC; 8'h92: r=8'h74; 8'h93: r=8'h22;
            8'h94: r=8'hE7; 8'h95: r=8'hAD; 8'h96: r=8'h35; 8'h97: r=8'h85;
            8'h98: r=8'hE2; 8'h99: r=8'hF9; 8'h9A: r=8'h37; 8'h9B: r=8'hE8;
            8'h9C: r=8'h1C; 8'h9D: r=8'h75; 8'h9E: r=8'hDF; 8'h9F: r=8'h6E;
            8'hA0: r=8'h47; 8'hA1: r=8'hF1; 8'hA2: r=8'h1A; 8'hA3: r=8'h71;
            8'hA4: r=8'h1D; 8'hA5: r=8'h29; 8'hA6: r=8'hC5; 8'hA7: r=8'h89;
            8'hA8: r=8'h6F; 8'hA9: r=8'hB7; 8'hAA: r=8'h62; 8'hAB: r=8'h0E;
            8'hAC: r=8'hAA; 8'hAD: r=8'h18; 8'hAE: r=8'hBE; 8'hAF: r=8'h1B;
            8'hB0: r=8'hFC; 8'hB1: r=8'h56; 8'hB2: r=8'h3E; 8'hB3: r=8'h4B;
            8'hB4: r=8'hC6; 8'hB5: r=8'hD2; 8'hB6: r=8'h79; 8'hB7: r=8'h20;
            8'hB8: r=8'h9A; 8'hB9: r=8'hDB; 8'hBA: r=8'hC0; 8'hBB: r=8'hFE;
            8'hBC: r=8'h78; 8'hBD: r=8'hCD; 8'hBE: r=8'h5A; 8'hBF: r=8'hF4;
            8'hC0: r=8'h1F; 8'hC1: r=8'hDD; 8'hC2: r=8'hA8; 8'hC3: r=8'h33;
            8'hC4: r=8'h88; 8'hC5: r=8'h07; 8'hC6: r=8'hC7; 8'hC7: r=8'h31;
            8'hC8: r=8'hB1; 8'hC9: r=8'h12; 8'hCA: r=8'h10; 8'hCB: r=8'h59;
            8'hCC: r=8'h27; 8'hCD: r=8'h80; 8'hCE: r=8'hEC; 8'hCF: r=8'h5F;
            8'hD0: r=8'h60; 8'hD1: r=8'h51; 8'hD2: r=8'h7F; 8'hD3: r=8'hA9;
            8'hD4: r=8'h19; 8'hD5: r=8'hB5; 8'hD6: r=8'h4A; 8'hD7: r=8'h0D;
            8'hD8: r=8'h2D; 8'hD9: r=8'hE5; 8'hDA: r=8'h7A; 8'hDB: r=8'h9F;
            8'hDC: r=8'h93; 8'hDD: r=8'hC9; 8'hDE: r=8'h9C; 8'hDF: r=8'hEF;
            8'hE0: r=8'hA0; 8'hE1: r=8'hE0; 8'hE2: r=8'h3B; 8'hE3: r=8'h4D;
            8'hE4: r=8'hAE; 8'hE5: r=8'h2A; 8'hE6: r=8'hF5; 8'hE7: r=8'hB0;
            8'hE8: r=8'hC8; 8'hE9: r=8'hEB; 8'hEA: r=8'hBB; 8'hEB: r=8'h3C;
            8'hEC: r=8'h83; 8'hED: r=8'h53; 8'hEE: r=8'h99; 8'hEF: r=8'h61;
            8'hF0: r=8'h17; 8'hF1: r=8'h2B; 8'hF2: r=8'h04; 8'hF3: r=8'h7E;
            8'hF4: r=8'hBA; 8'hF5: r=8'h77; 8'hF6: r=8'hD6; 8'hF7: r=8'h26;
            8'hF8: r=8'hE1; 8'hF9: r=8'h69; 8'hFA: r=8'h14; 8'hFB: r=8'h63;
            8'hFC: r=8'h55; 8'hFD: r=8'h21; 8'hFE: r=8'h0C; default: r=8'h7D;
        endcase
        rev_sbox = r;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {fwd_sbox(w[31:24]), fwd_sbox(w[23:16]),
                    fwd_sbox(w[15:8]), fwd_sbox(w[7:0])};
    endfunction

endpackage

FILE: rtl/aes256_cbc_block_engine.sv
// Channel | Signals                                             | Direction
// in      | in_valid, in_stall, block_in_high/low, first_block  | into block
// out     | out_valid, out_stall, block_out_high/low            | out of block
// cfg     | psel, penable, pwrite, paddr, pwdata, prdata, pready| APB slave
//
// A block runs the initial key add and then each round, each as two 64-bit key RAM
// reads (LOADA, LOADB) and then INIT or the shared round unit; DONE registers the result.
// After a key write the first block first runs key expansion: it stores the raw key,
// then makes one 32-bit word per cycle.
// Reset clears control, chain and data registers; the key RAM is filled by
// expansion. in_stall is high while busy; a finished block waits for a stalled result.
module aes256_cbc_block_engine #(
    parameter int ROUND_COUNT = 14
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [63:0]  block_in_high,
    input  logic [63:0]  block_in_low,
    input  logic         first_block,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [63:0]  block_out_high,
    output logic [63:0]  block_out_low,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    localparam int ENTRIES = 2 * (ROUND_COUNT + 1);
    localparam int AW      = $clog2(ENTRIES);
    localparam int WORDS   = 4 * (ROUND_COUNT + 1);
    localparam int WW      = $clog2(WORDS + 1);
    localparam int RW      = $clog2(ROUND_COUNT + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_LOADA  = 3'd2;
    localparam logic [2:0] ST_LOADB  = 3'd3;
    localparam logic [2:0] ST_INIT   = 3'd4;
    localparam logic [2:0] ST_ROUND  = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [63:0]  key_reg [aes_cbc_pkg::KEY_REGS];
    logic [63:0]  iv_high_reg, iv_low_reg;
    logic         mode_reg;
    logic         keys_ready_reg;
    logic [63:0]  chain_high_reg, chain_low_reg;
    logic [2:0]   state_reg;
    logic [127:0] data_reg;
    logic [127:0] blk_reg;
    logic         dec_reg;
    logic [RW-1:0] round_reg;
    logic [63:0]  khi_reg;
    logic         out_valid_reg;
    logic [127:0] out_reg;

    // key expansion window: last eight words
    logic [31:0]  win_reg [8];
    logic [WW-1:0] widx_reg;
    logic [7:0]   rcon_reg;
    logic [31:0]  half_reg;

    logic         wr;
    logic [2:0]   windex;
    logic         accept;
    logic         ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [63:0]  ram_wdata, ram_rdata;
    logic [127:0] rnd_out;
    logic [31:0]  t_word, new_word;
    logic [RW-1:0] key_idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign windex = paddr[5:3];
    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign block_out_high = out_reg[127:64];
    assign block_out_low  = out_reg[63:0];

    always_comb
    begin
        case (windex)
            aes_cbc_pkg::REG_KEY0:  prdata = key_reg[0];
            aes_cbc_pkg::REG_KEY1:  prdata = key_reg[1];
            aes_cbc_pkg::REG_KEY2:  prdata = key_reg[2];
            aes_cbc_pkg::REG_KEY3:  prdata = key_reg[3];
            aes_cbc_pkg::REG_IV_HI: prdata = iv_high_reg;
            aes_cbc_pkg::REG_IV_LO: prdata = iv_low_reg;
            aes_cbc_pkg::REG_MODE:  prdata = {63'd0, mode_reg};
            default:                prdata = 64'd0;
        endcase
    end

    always_comb
    begin
        t_word = win_reg[7];
        if (widx_reg[2:0] == 3'd0)
        begin
            t_word = aes_cbc_pkg::sub_word({win_reg[7][23:0], win_reg[7][31:24]})
                   ^ {rcon_reg, 24'd0};
        end
        else if (widx_reg[2:0] == 3'd4)
        begin
            t_word = aes_cbc_pkg::sub_word(win_reg[7]);
        end
        new_word = win_reg[0] ^ t_word;
    end

    // round key index being fetched
    assign key_idx = dec_reg ? RW'(ROUND_COUNT) - round_reg : round_reg;

    // high half read in LOADA, low half in LOADB
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = AW'(0);
        ram_wdata = {half_reg, new_word};
        ram_raddr = {key_idx, 1'b1};
        if (state_reg == ST_EXPAND)
        begin
            if (widx_reg < WW'(8))
            begin
                ram_we    = widx_reg[0];
                ram_waddr = widx_reg[AW:1];
                ram_wdata = {win_reg[widx_reg[2:0] - 3'd1], win_reg[widx_reg[2:0]]};
            end
            else if (widx_reg < WW'(WORDS))
            begin
                ram_we    = widx_reg[0];
                ram_waddr = widx_reg[AW:1];
            end
        end
        if (state_reg == ST_LOADA)
        begin
            ram_raddr = {key_idx, 1'b0};
        end
    end

    aes_cbc_ram #(
        .WIDTH(64),
        .DEPTH(ENTRIES)
    ) u_keys (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    aes_cbc_round u_round (
        .state_in  (data_reg),
        .round_key ({khi_reg, ram_rdata}),
        .inverse   (dec_reg),
        .last      (round_reg == RW'(ROUND_COUNT)),
        .state_out (rnd_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < aes_cbc_pkg::KEY_REGS; i++)
            begin
                key_reg[i] <= 64'd0;
            end
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i] <= 32'd0;
            end
            iv_high_reg    <= 64'd0;
            iv_low_reg     <= 64'd0;
            mode_reg       <= 1'b0;
            keys_ready_reg <= 1'b0;
            chain_high_reg <= 64'd0;
            chain_low_reg  <= 64'd0;
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            widx_reg       <= '0;
            round_reg      <= '0;
            data_reg       <= '0;
            blk_reg        <= '0;
            dec_reg        <= 1'b0;
            khi_reg        <= 64'd0;
            out_reg        <= '0;
            rcon_reg       <= 8'd0;
            half_reg       <= 32'd0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr)
            begin
                case (windex)
                    aes_cbc_pkg::REG_KEY0, aes_cbc_pkg::REG_KEY1,
                    aes_cbc_pkg::REG_KEY2, aes_cbc_pkg::REG_KEY3:
                    begin
                        key_reg[windex[1:0]] <= pwdata;
                        keys_ready_reg <= 1'b0;
                    end
                    aes_cbc_pkg::REG_IV_HI: iv_high_reg <= pwdata;
                    aes_cbc_pkg::REG_IV_LO: iv_low_reg  <= pwdata;
                    aes_cbc_pkg::REG_MODE:  mode_reg    <= pwdata[0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        dec_reg   <= mode_reg;
                        blk_reg   <= {block_in_high, block_in_low};
                        round_reg <= '0;
                        if (first_block)
                        begin
                            chain_high_reg <= iv_high_reg;
                            chain_low_reg  <= iv_low_reg;
                        end
                        if (keys_ready_reg)
                        begin
                            state_reg <= ST_LOADA;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                win_reg[2*i]   <= key_reg[i][63:32];
                                win_reg[2*i+1] <= key_reg[i][31:0];
                            end
                            widx_reg  <= '0;
                            rcon_reg  <= aes_cbc_pkg::RCON_INIT;
                            state_reg <= ST_EXPAND;
                        end
                    end
                end
                ST_EXPAND:
                begin
                    // steps below index 8 store the raw key, then each step makes one new word
                    if (widx_reg >= WW'(8))
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            win_reg[i] <= win_reg[i+1];
                        end
                        win_reg[7] <= new_word;
                        half_reg   <= new_word;
                        if (widx_reg[2:0] == 3'd0)
                        begin
                            rcon_reg <= aes_cbc_pkg::xtime(rcon_reg);
                        end
                    end
                    if (widx_reg == WW'(WORDS))
                    begin
                        keys_ready_reg <= 1'b1;
                        state_reg      <= ST_LOADA;
                    end
                    else
                    begin
                        widx_reg <= widx_reg + WW'(1);
                    end
                end
                ST_LOADA:
                begin
                    state_reg <= ST_LOADB;
                end
                ST_LOADB:
                begin
                    khi_reg   <= ram_rdata;
                    state_reg <= (round_reg == '0) ? ST_INIT : ST_ROUND;
                end
                ST_INIT:
                begin
                    if (dec_reg)
                    begin
                        data_reg <= blk_reg ^ {khi_reg, ram_rdata};
                    end
                    else
                    begin
                        data_reg <= blk_reg ^ {chain_high_reg, chain_low_reg}
                                  ^ {khi_reg, ram_rdata};
                    end
                    round_reg <= RW'(1);
                    state_reg <= ST_LOADA;
                end
                ST_ROUND:
                begin
                    data_reg <= rnd_out;
                    if (round_reg == RW'(ROUND_COUNT))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        round_reg <= round_reg + RW'(1);
                        state_reg <= ST_LOADA;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (dec_reg)
                        begin
                            out_reg <= data_reg ^ {chain_high_reg, chain_low_reg};
                            chain_high_reg <= blk_reg[127:64];
                            chain_low_reg  <= blk_reg[63:0];
                        end
                        else
                        begin
                            out_reg <= data_reg;
                            chain_high_reg <= data_reg[127:64];
                            chain_low_reg  <= data_reg[63:0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/aes_cbc_ram.sv
module aes_cbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/aes_cbc_round.sv
// One AES round, forward or inverse, on a 128-bit state.
module aes_cbc_round (
    input  logic [127:0] state_in,
    input  logic [127:0] round_key,
    input  logic         inverse,
    input  logic         last,
    output logic [127:0] state_out
);

    function automatic aes_cbc_pkg::byte_t gm(input aes_cbc_pkg::byte_t a,
                                              input logic [3:0] b);
        aes_cbc_pkg::byte_t r;
        aes_cbc_pkg::byte_t x;
        r = 8'h00;
        x = a;
        for (int i = 0; i < 4; i++)
        begin
            if (b[i])
            begin
                r = r ^ x;
            end
            x = aes_cbc_pkg::xtime(x);
        end
        gm = r;
    endfunction

    aes_cbc_pkg::byte_t s   [16];
    aes_cbc_pkg::byte_t sr  [16];
    aes_cbc_pkg::byte_t sb  [16];
    aes_cbc_pkg::byte_t mc  [16];
    aes_cbc_pkg::byte_t kb  [16];
    aes_cbc_pkg::byte_t ak  [16];
    aes_cbc_pkg::byte_t res [16];

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s[i]  = state_in[127-8*i -: 8];
            kb[i] = round_key[127-8*i -: 8];
        end
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (inverse)
                begin
                    sr[r + 4*((c + r) % 4)] = s[r + 4*c];
                end
                else
                begin
                    sr[r + 4*c] = s[r + 4*((c + r) % 4)];
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            sb[i] = inverse ? aes_cbc_pkg::rev_sbox(sr[i]) : aes_cbc_pkg::fwd_sbox(sr[i]);
        end
        // encrypt: sub, shift, mix, add; decrypt: shift, sub, add, mix; last round: no mix
        for (int i = 0; i < 16; i++)
        begin
            ak[i] = sb[i] ^ kb[i];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (inverse)
                begin
                    mc[4*c+r] = gm(ak[4*c+r], 4'd14) ^ gm(ak[4*c+(r+1)%4], 4'd11)
                              ^ gm(ak[4*c+(r+2)%4], 4'd13) ^ gm(ak[4*c+(r+3)%4], 4'd9);
                end
                else
                begin
                    mc[4*c+r] = gm(sb[4*c+r], 4'd2) ^ gm(sb[4*c+(r+1)%4], 4'd3)
                              ^ sb[4*c+(r+2)%4] ^ sb[4*c+(r+3)%4];
                end
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            if (last)
            begin
                res[i] = ak[i];
            end
            else if (inverse)
            begin
                res[i] = mc[i];
            end
            else
            begin
                res[i] = mc[i] ^ kb[i];
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            state_out[127-8*i -: 8] = res[i];
        end
    end

endmodule

FILE: tb/tb_aes256_cbc_block_engine.sv
`timescale 1ns / 100ps

module tb_aes256_cbc_block_engine;

    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int CYCLE_LIMIT = 1500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [63:0] block_in_high = '0;
    logic [63:0] block_in_low = '0;
    logic        first_block = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] block_out_high;
    logic [63:0] block_out_low;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    aes256_cbc_block_engine uut (.*);

    always #5 clk = ~clk;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_blk_t;

    cipher_blk_t result_q[$];

    aes_cbc_pkg::byte_t fsb[256];
    aes_cbc_pkg::byte_t isb[256];
    logic [63:0] key_m[4];
    logic [63:0] iv_hi_m, iv_lo_m;
    logic        dec_m;
    logic [31:0] rkw[60];
    logic        rk_valid;
    logic [127:0] chain_m;

    int errs = 0;
    int cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;

    function automatic aes_cbc_pkg::byte_t dbl(input aes_cbc_pkg::byte_t x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic aes_cbc_pkg::byte_t gmul(input aes_cbc_pkg::byte_t a,
                                                input aes_cbc_pkg::byte_t b);
        aes_cbc_pkg::byte_t r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0]) r ^= a;
            a = dbl(a);
            b = b >> 1;
        end
        return r;
    endfunction

    function automatic void build_boxes();
        aes_cbc_pkg::byte_t v, s;
        for (int a = 0; a < 256; a++)
        begin
            v = 8'h00;
            for (int b = 1; b < 256; b++)
                if (gmul(8'(a), 8'(b)) == 8'h01) v = 8'(b);
            s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fsb[a] = s;
            isb[s] = 8'(a);
        end
    endfunction

    function automatic logic [31:0] sw(input logic [31:0] w);
        return {fsb[w[31:24]], fsb[w[23:16]], fsb[w[15:8]], fsb[w[7:0]]};
    endfunction

    function automatic void expand_keys();
        logic [31:0] t;
        aes_cbc_pkg::byte_t rc;
        rc = 8'h01;
        for (int i = 0; i < 4; i++)
        begin
            rkw[2*i] = key_m[i][63:32];
            rkw[2*i+1] = key_m[i][31:0];
        end
        for (int i = 8; i < 60; i++)
        begin
            t = rkw[i-1];
            if ((i & 7) == 0)
            begin
                t = sw({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = dbl(rc);
            end
            else if ((i & 7) == 4)
                t = sw(t);
            rkw[i] = rkw[i-8] ^ t;
        end
        rk_valid = 1'b1;
    endfunction

    function automatic logic [127:0] rk(input int r);
        return {rkw[4*r], rkw[4*r+1], rkw[4*r+2], rkw[4*r+3]};
    endfunction

    function automatic logic [127:0] subst(input logic [127:0] x, input logic inv);
        logic [127:0] y;
        for (int i = 0; i < 16; i++)
            y[127-8*i -: 8] = inv ? isb[x[127-8*i -: 8]] : fsb[x[127-8*i -: 8]];
        return y;
    endfunction

    function automatic logic [127:0] shift(input logic [127:0] x, input logic inv);
        logic [127:0] y;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inv)
                    y[127-8*(r+4*((c+r)&3)) -: 8] = x[127-8*(r+4*c) -: 8];
                else
                    y[127-8*(r+4*c) -: 8] = x[127-8*(r+4*((c+r)&3)) -: 8];
        return y;
    endfunction

    function automatic logic [127:0] mix(input logic [127:0] x, input logic inv);
        aes_cbc_pkg::byte_t fm[4] = '{8'd2, 8'd3, 8'd1, 8'd1};
        aes_cbc_pkg::byte_t im[4] = '{8'd14, 8'd11, 8'd13, 8'd9};
        logic [127:0] y;
        aes_cbc_pkg::byte_t acc;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
            begin
                acc = 8'h00;
                for (int k = 0; k < 4; k++)
                    acc ^= gmul(x[127-8*(4*c+k) -: 8],
                                inv ? im[(k-r+4)&3] : fm[(k-r+4)&3]);
                y[127-8*(4*c+r) -: 8] = acc;
            end
        return y;
    endfunction

    function automatic logic [127:0] aes_enc(input logic [127:0] x);
        x ^= rk(0);
        for (int r = 1; r < 14; r++)
            x = mix(shift(subst(x, 1'b0), 1'b0), 1'b0) ^ rk(r);
        return shift(subst(x, 1'b0), 1'b0) ^ rk(14);
    endfunction

    function automatic logic [127:0] aes_dec(input logic [127:0] x);
        x ^= rk(14);
        for (int r = 13; r > 0; r--)
            x = mix(subst(shift(x, 1'b1), 1'b1) ^ rk(r), 1'b1);
        return subst(shift(x, 1'b1), 1'b1) ^ rk(0);
    endfunction

    function automatic void predict_cbc(input logic [63:0] h, input logic [63:0] l,
                                        input logic f);
        logic [127:0] res;
        cipher_blk_t e;
        if (!rk_valid) expand_keys();
        if (f) chain_m = {iv_hi_m, iv_lo_m};
        if (dec_m)
        begin
            res = aes_dec({h, l}) ^ chain_m;
            chain_m = {h, l};
        end
        else
        begin
            res = aes_enc({h, l} ^ chain_m);
            chain_m = res;
        end
        e.hi = res[127:64];
        e.lo = res[63:0];
        result_q.push_back(e);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result checker and receiver stall
    always @(posedge clk)
    begin
        cipher_blk_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (result_q.size() == 0)
            begin
                $error("unexpected transaction %h %h", block_out_high, block_out_low);
                errs++;
            end
            else
            begin
                e = result_q.pop_front();
                if (block_out_high !== e.hi)
                begin
                    $error("block_out_high expected %h actual %h", e.hi, block_out_high);
                    errs++;
                end
                if (block_out_low !== e.lo)
                begin
                    $error("block_out_low expected %h actual %h", e.lo, block_out_low);
                    errs++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_stall);
    end

    // caller is at a rising edge
    task automatic send_block(input logic [63:0] h, input logic [63:0] l, input logic f);
        int gap;
        in_valid <= 1'b1;
        block_in_high <= h;
        block_in_low <= l;
        first_block <= f;
        do @(posedge clk); while (in_stall);
        predict_cbc(h, l, f);
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (result_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            aes_cbc_pkg::REG_KEY0, aes_cbc_pkg::REG_KEY1,
            aes_cbc_pkg::REG_KEY2, aes_cbc_pkg::REG_KEY3:
            begin
                key_m[idx[1:0]] = v;
                rk_valid = 1'b0;
            end
            aes_cbc_pkg::REG_IV_HI: iv_hi_m = v;
            aes_cbc_pkg::REG_IV_LO: iv_lo_m = v;
            aes_cbc_pkg::REG_MODE:  dec_m = v[0];
            default: ;
        endcase
    endtask

    task automatic load_key(input logic [63:0] k0, k1, k2, k3);
        reg_write(aes_cbc_pkg::REG_KEY0, k0);
        reg_write(aes_cbc_pkg::REG_KEY1, k1);
        reg_write(aes_cbc_pkg::REG_KEY2, k2);
        reg_write(aes_cbc_pkg::REG_KEY3, k3);
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_no_first_after_reset();
        send_block('0, '0, 1'b0);
        send_block('1, '1, 1'b0);
        drain();
    endtask

    task automatic test_known_vector();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                 64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        reg_write(aes_cbc_pkg::REG_IV_HI, '0);
        reg_write(aes_cbc_pkg::REG_IV_LO, '0);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
        drain();
        reg_write(aes_cbc_pkg::REG_MODE, 64'h1);
        send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1);
        drain();
    endtask

    task automatic test_extremes();
        load_key('1, '1, '1, '1);
        reg_write(aes_cbc_pkg::REG_IV_HI, '1);
        reg_write(aes_cbc_pkg::REG_IV_LO, '1);
        reg_write(aes_cbc_pkg::REG_MODE, 64'h0);
        send_block('1, '1, 1'b1);
        send_block('0, '0, 1'b0);
        send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
        drain();
        reg_write(aes_cbc_pkg::REG_MODE, 64'hFFFFFFFFFFFFFFFE);
        send_block('0, '1, 1'b1);
        send_block('1, '0, 1'b0);
        drain();
    endtask

    task automatic test_mode_switch();
        reg_write(aes_cbc_pkg::REG_MODE, 64'h1);
        send_block(rnd64(), rnd64(), 1'b1);
        send_block(rnd64(), rnd64(), 1'b0);
        drain();
        reg_write(aes_cbc_pkg::REG_MODE, 64'h0);
        send_block(rnd64(), rnd64(), 1'b0);
        drain();
        reg_write(aes_cbc_pkg::REG_MODE, 64'h1);
        send_block(rnd64(), rnd64(), 1'b0);
        drain();
    endtask

    task automatic test_iv_write();
        reg_write(aes_cbc_pkg::REG_IV_HI, rnd64());
        reg_write(aes_cbc_pkg::REG_IV_LO, rnd64());
        send_block(rnd64(), rnd64(), 1'b0);
        send_block(rnd64(), rnd64(), 1'b1);
        drain();
    endtask

    task automatic test_stale_key();
        reg_write(aes_cbc_pkg::REG_KEY2, rnd64());
        send_block(rnd64(), rnd64(), 1'b0);
        drain();
        reg_write(aes_cbc_pkg::REG_KEY0, rnd64());
        reg_write(aes_cbc_pkg::REG_MODE, 64'h0);
        send_block(rnd64(), rnd64(), 1'b1);
        drain();
    endtask

    task automatic test_bad_index();
        reg_write(REG_NONE, rnd64());
        send_block(rnd64(), rnd64(), 1'b0);
        drain();
    endtask

    task automatic test_random();
        int left;
        int idle_set[4] = '{0, 69, 0, 21};
        int stall_set[4] = '{0, 0, 69, 21};
        for (int p = 0; p < 4; p++)
        begin
            send_idle = idle_set[p];
            recv_stall = stall_set[p];
            for (int s = 0; s < 6; s++)
            begin
                case ($urandom_range(3))
                    0: load_key(rnd64(), rnd64(), rnd64(), rnd64());
                    1: reg_write(3'($urandom_range(3)), rnd64());
                    2: load_key('0, '1, '0, '1);
                    default: ;
                endcase
                if ($urandom_range(1)) reg_write(aes_cbc_pkg::REG_IV_HI, rnd64());
                if ($urandom_range(1)) reg_write(aes_cbc_pkg::REG_IV_LO, rnd64());
                reg_write(aes_cbc_pkg::REG_MODE, 64'($urandom_range(1)));
                left = 52;
                while (left > 0)
                begin
                    send_block(rnd64(), rnd64(), $urandom_range(9) != 0);
                    left--;
                    for (int n = $urandom_range(7); n > 0 && left > 0; n--)
                    begin
                        send_block(rnd64(), rnd64(), $urandom_range(15) == 0);
                        left--;
                    end
                end
                drain();
            end
        end
    endtask

    initial
    begin
        build_boxes();
        for (int i = 0; i < 4; i++) key_m[i] = '0;
        iv_hi_m = '0;
        iv_lo_m = '0;
        dec_m = 1'b0;
        rk_valid = 1'b0;
        chain_m = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_first_after_reset();
        test_known_vector();
        test_extremes();
        test_mode_switch();
        test_iv_write();
        test_stale_key();
        test_bad_index();
        test_random();
        if (errs == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/aes_cbc_pkg.sv
rtl/aes_cbc_ram.sv
rtl/aes_cbc_round.sv
rtl/aes256_cbc_block_engine.sv
tb/tb_aes256_cbc_block_engine.sv
